### rtl/ipv4sml_pkg.sv
// Package with the transaction types, command codes and mask helper of the subnet lookup.
package ipv4sml_pkg;

  // Default number of table entries.
  localparam int unsigned TABLE_DEPTH_DEF = 256;

  // Command codes carried in the input transaction.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Input transaction.
  typedef struct packed {
    logic        command;
    logic [31:0] address;
    logic [5:0]  prefix_length;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic is_member;
    logic table_full;
  } out_t;

  // One table entry as held in the memory.
  typedef struct packed {
    logic [31:0] base;
    logic [31:0] mask;
  } entry_t;

  // Turns a prefix length into a mask; lengths above 32 saturate to the full mask.
  function automatic logic [31:0] prefix_to_mask(input logic [5:0] len);
    logic [5:0] n;
    n = (len > 6'd32) ? 6'd32 : len;
    return ~(32'hFFFF_FFFF >> n);
  endfunction

endpackage

### rtl/ipv4_subnet_membership_lookup.sv
// Top level of the IPv4 subnet membership table: sorted entry memory, binary search and insert.
//
// The block holds up to TABLE_DEPTH subnets in one synchronous memory, sorted by base.
// It works on one transaction at a time. A lookup is accepted, runs a binary search
// with one memory read per step and then loads the result register from the response
// state. An insert runs the same search on a non-empty table, then moves every entry
// above the insert position up by one, one entry per cycle, and then writes the new
// entry. Each search step and each moved entry needs one read of the memory's single
// read port. An insert into a full table is answered without a search, with table_full
// set. A new transaction may be accepted while the previous result still waits in the
// output register.
module ipv4_subnet_membership_lookup #(
  parameter int unsigned TABLE_DEPTH = ipv4sml_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ipv4sml_pkg::in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ipv4sml_pkg::out_t  out_data
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_PLACE,
    S_RESP
  } state_t;

  // Entry memory.
  ipv4sml_pkg::entry_t mem [TABLE_DEPTH];

  state_t              state_r;
  logic                cmd_r;
  logic [31:0]         key_r;
  logic [31:0]         mask_r;
  logic [CNT_W-1:0]    lo_r;
  logic [CNT_W-1:0]    hi_r;
  logic [CNT_W-1:0]    mid_r;
  logic [IDX_W-1:0]    sh_r;
  logic                cand_hit_r;
  logic                full_r;
  logic [CNT_W-1:0]    count_r;
  logic                out_valid_r;
  ipv4sml_pkg::out_t   out_data_r;
  ipv4sml_pkg::entry_t rd_data_r;

  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  ipv4sml_pkg::entry_t wr_data;

  logic                in_fire;
  logic                resp_load;
  logic [31:0]         in_mask;
  logic                base_le;
  logic                hit_now;
  logic [CNT_W-1:0]    lo_nxt;
  logic [CNT_W-1:0]    hi_nxt;
  logic [CNT_W-1:0]    mid_nxt;
  logic [CNT_W-1:0]    span;
  logic [CNT_W-1:0]    count_m1;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign resp_load = (state_r == S_RESP) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_mask   = ipv4sml_pkg::prefix_to_mask(in_data.prefix_length);
  assign count_m1  = count_r - 1'b1;

  // Search step: compare the entry just read with the key and narrow the interval.
  assign base_le = (rd_data_r.base <= key_r);
  assign hit_now = ((key_r & rd_data_r.mask) == rd_data_r.base);
  assign lo_nxt  = base_le ? CNT_W'(mid_r + 1'b1) : lo_r;
  assign hi_nxt  = base_le ? hi_r : mid_r;
  assign span    = hi_nxt - lo_nxt;
  assign mid_nxt = lo_nxt + (span >> 1);

  // Memory port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data_r;
    case (state_r)
      S_IDLE: begin
        rd_en   = in_fire && (count_r != '0);
        rd_addr = IDX_W'(count_r >> 1);
      end
      S_SEARCH: begin
        if (lo_nxt < hi_nxt) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(mid_nxt);
        end else if (count_r > lo_nxt) begin
          // Insert continues with the topmost entry to be moved.
          rd_en   = (cmd_r == ipv4sml_pkg::CMD_INSERT);
          rd_addr = IDX_W'(count_m1);
        end
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(sh_r + 1'b1);
        wr_data = rd_data_r;
        rd_en   = (CNT_W'(sh_r) > lo_r);
        rd_addr = IDX_W'(sh_r - 1'b1);
      end
      S_PLACE: begin
        wr_en        = 1'b1;
        wr_addr      = IDX_W'(lo_r);
        wr_data.base = key_r;
        wr_data.mask = mask_r;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Sequencer, table count and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The result register is filled from the response state and emptied by the consumer.
      if (resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cmd_r      <= in_data.command;
            lo_r       <= '0;
            hi_r       <= count_r;
            mid_r      <= count_r >> 1;
            cand_hit_r <= 1'b0;
            full_r     <= 1'b0;
            mask_r     <= in_mask;
            if (in_data.command == ipv4sml_pkg::CMD_INSERT) begin
              key_r <= in_data.address & in_mask;
              if (count_r == CNT_W'(TABLE_DEPTH)) begin
                full_r  <= 1'b1;
                state_r <= S_RESP;
              end else if (count_r != '0) begin
                state_r <= S_SEARCH;
              end else begin
                state_r <= S_PLACE;
              end
            end else begin
              key_r <= in_data.address;
              if (count_r != '0) begin
                state_r <= S_SEARCH;
              end else begin
                state_r <= S_RESP;
              end
            end
          end
        end
        S_SEARCH: begin
          lo_r  <= lo_nxt;
          hi_r  <= hi_nxt;
          mid_r <= mid_nxt;
          if (base_le) begin
            cand_hit_r <= hit_now;
          end
          if (lo_nxt >= hi_nxt) begin
            if (cmd_r == ipv4sml_pkg::CMD_LOOKUP) begin
              state_r <= S_RESP;
            end else if (count_r > lo_nxt) begin
              sh_r    <= IDX_W'(count_m1);
              state_r <= S_SHIFT;
            end else begin
              state_r <= S_PLACE;
            end
          end
        end
        S_SHIFT: begin
          if (CNT_W'(sh_r) > lo_r) begin
            sh_r <= sh_r - 1'b1;
          end else begin
            state_r <= S_PLACE;
          end
        end
        S_PLACE: begin
          count_r <= count_r + 1'b1;
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (resp_load) begin
            out_data_r.is_member <= cand_hit_r && (cmd_r == ipv4sml_pkg::CMD_LOOKUP);
            out_data_r.table_full <= full_r;
            state_r              <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/ipv4sml_checker.sv
// Port-level checker for the subnet lookup and its bind to the top level.
module ipv4sml_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input ipv4sml_pkg::in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input ipv4sml_pkg::out_t out_data
);

  // A result waiting for the consumer keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A result never reports both a hit and a full table.
  a_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.is_member && out_data.table_full))
    else $error("result has both flags set");

  // The block works on one transaction at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("transaction accepted while busy");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A lookup is never answered with table_full in the cycle after acceptance.
  a_lookup_no_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.command == ipv4sml_pkg::CMD_LOOKUP)
      |=> !(out_valid && out_data.table_full && $rose(out_valid)))
    else $error("lookup answered as full");

endmodule

bind ipv4_subnet_membership_lookup ipv4sml_checker u_ipv4sml_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
